// ----- rtl/core/llr_pkg.sv -----
// ----------------------------------------------------------------------------
// llr_pkg
// shared types and constants of the lanczos line resampler
// ----------------------------------------------------------------------------
package llr_pkg;

  localparam int unsigned MaxLine    = 4096;
  localparam int unsigned MaxTaps    = 16;
  localparam int unsigned FracBits   = 14;
  localparam int unsigned MaxResults = 64;

  localparam int unsigned LineAw  = 12;
  localparam int unsigned LenW    = 13;
  localparam int unsigned TapW    = 5;
  localparam int unsigned StepW   = 29;
  localparam int unsigned WeightW = 17;
  localparam int unsigned WaddrW  = 16;
  localparam int unsigned ChanW   = 16;
  localparam int unsigned ProdW   = 34;
  localparam int unsigned AccW    = 38;
  localparam int unsigned CntW    = 7;
  localparam int unsigned CfgAw   = 8;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_WEIGHT = 2'd1,
    KIND_START  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [CfgAw-1:0] {
    REG_NEAREST = 8'd0,
    REG_SRC_LEN = 8'd1,
    REG_TGT_LEN = 8'd2,
    REG_TAPS    = 8'd3,
    REG_STEP    = 8'd4
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK_RD,
    ST_CHECK_EV,
    ST_MAC,
    ST_FINISH
  } state_e;

  typedef struct packed {
    kind_e               kind;
    logic [WaddrW-1:0]   idx;
    logic [WeightW-1:0]  value;
    logic [ChanW-1:0]    a;
    logic [ChanW-1:0]    b;
    logic [ChanW-1:0]    c;
  } item_t;

  typedef struct packed {
    logic              nearest;
    logic [LenW-1:0]   src;
    logic [LenW-1:0]   tgt;
    logic [TapW-1:0]   taps;
    logic [StepW-1:0]  step;
  } cfg_t;

endpackage

// ----- rtl/core/llr_front.sv -----
// ----------------------------------------------------------------------------
// llr_front
// configuration registers and input item classification
// ----------------------------------------------------------------------------
module llr_front import llr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAw-1:0]    cfg_index_i,
  input  logic [StepW-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic [WaddrW-1:0]   table_index_i,
  input  logic signed [WeightW-1:0] table_value_i,
  input  logic [ChanW-1:0]    chan_a_i,
  input  logic [ChanW-1:0]    chan_b_i,
  input  logic [ChanW-1:0]    chan_c_i,
  input  logic                q_full_i,
  output logic                push_o,
  output item_t               item_o,
  output cfg_t                cfg_o
);

  logic             nearest_q;
  logic [LenW-1:0]  src_q;
  logic [LenW-1:0]  tgt_q;
  logic [TapW-1:0]  taps_q;
  logic [StepW-1:0] step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nearest_q <= 1'b0;
      src_q     <= LenW'(MaxLine);
      tgt_q     <= LenW'(MaxLine);
      taps_q    <= TapW'(6);
      step_q    <= StepW'(65536);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_NEAREST: nearest_q <= cfg_data_i[0];
        REG_SRC_LEN: src_q     <= cfg_data_i[LenW-1:0];
        REG_TGT_LEN: tgt_q     <= cfg_data_i[LenW-1:0];
        REG_TAPS:    taps_q    <= cfg_data_i[TapW-1:0];
        REG_STEP:    step_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturate lengths and the tap count to their legal ranges
  always_comb begin
    cfg_o.nearest = nearest_q;
    cfg_o.step    = step_q;
    if (src_q == '0) cfg_o.src = LenW'(1);
    else if (src_q > LenW'(MaxLine)) cfg_o.src = LenW'(MaxLine);
    else cfg_o.src = src_q;
    if (tgt_q == '0) cfg_o.tgt = LenW'(1);
    else if (tgt_q > LenW'(MaxLine)) cfg_o.tgt = LenW'(MaxLine);
    else cfg_o.tgt = tgt_q;
    if (taps_q == '0) cfg_o.taps = TapW'(1);
    else if (taps_q > TapW'(MaxTaps)) cfg_o.taps = TapW'(MaxTaps);
    else cfg_o.taps = taps_q;
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.kind  = kind_e'(kind_i);
    item_o.idx   = table_index_i;
    item_o.value = table_value_i;
    item_o.a     = chan_a_i;
    item_o.b     = chan_b_i;
    item_o.c     = chan_c_i;
  end

endmodule

// ----- rtl/core/llr_queue.sv -----
// ----------------------------------------------------------------------------
// llr_queue
// two-entry item queue between front and back
// ----------------------------------------------------------------------------
module llr_queue import llr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t head_o,
  output logic  empty_o,
  output logic  full_o
);

  item_t      mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = !wr_q;
    if (pop_i) rd_d = !rd_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

// ----- rtl/core/llr_back.sv -----
// ----------------------------------------------------------------------------
// llr_back
// table stores, line store and the output sequencer with tap mac pipeline
// ----------------------------------------------------------------------------
module llr_back import llr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  item_t              head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ChanW-1:0]   res_a_o,
  output logic [ChanW-1:0]   res_b_o,
  output logic [ChanW-1:0]   res_c_o,
  output logic [LineAw-1:0]  out_position_o,
  output logic               run_last_o,
  output logic               line_done_o
);

  logic [3*ChanW-1:0]  line_mem [MaxLine];
  logic [WeightW-1:0]  weight_mem [2**WaddrW];
  logic [LineAw-1:0]   win_mem [MaxLine];

  logic [3*ChanW-1:0]  line_rd_q;
  logic [WeightW-1:0]  w_rd_q;
  logic [LineAw-1:0]   win_rd_q;
  logic [LineAw-1:0]   line_raddr;
  logic                line_we, w_we, win_we;

  state_e              state_q, state_d;
  logic [LenW-1:0]     prx_q, prx_d;
  logic [LenW-1:0]     nxt_q, nxt_d;
  logic [StepW-1:0]    pos_q, pos_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  logic                pend_v_q, pend_v_d;
  logic [ChanW-1:0]    pa_q, pa_d, pb_q, pb_d, pc_q, pc_d;
  logic [LineAw-1:0]   ppos_q, ppos_d;
  logic                pdone_q, pdone_d;

  logic                ov_q, ov_d;
  logic [ChanW-1:0]    oa_q, oa_d, ob_q, ob_d, oc_q, oc_d;
  logic [LineAw-1:0]   opos_q, opos_d;
  logic                olast_q, olast_d, odone_q, odone_d;

  logic [TapW-1:0]     t_q, t_d;
  logic [LenW-1:0]     p_q, p_d;
  logic [WaddrW-1:0]   widx_q, widx_d;
  logic                v1_q, v1_d, v2_q, v2_d;
  logic signed [ProdW-1:0] pra_q, pra_d, prb_q, prb_d, prc_q, prc_d;
  logic signed [AccW-1:0]  aca_q, aca_d, acb_q, acb_d, acc_q, acc_d;

  logic [LenW-1:0]     src_m1;
  logic [LenW-1:0]     near_idx;
  logic [LenW-1:0]     win_end;
  logic [LenW-1:0]     p_clamp;
  logic [17:0]         wbase;
  logic                rdy;
  logic                slot_free;
  logic                eol;
  logic signed [WeightW-1:0] wsig;

  function automatic logic [ChanW-1:0] round_clamp(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] r;
    logic signed [AccW-1:0] q;
    r = acc + AccW'(2**(FracBits-1));
    q = r >>> FracBits;
    if (q < 0) return '0;
    else if (q > AccW'(65535)) return '1;
    else return q[ChanW-1:0];
  endfunction

  assign src_m1    = cfg_i.src - LenW'(1);
  assign near_idx  = (pos_q[StepW-1:16] > src_m1) ? src_m1 : pos_q[StepW-1:16];
  assign win_end   = ({1'b0, win_rd_q} + LenW'(cfg_i.taps) - LenW'(1) > src_m1) ?
                     src_m1 : {1'b0, win_rd_q} + LenW'(cfg_i.taps) - LenW'(1);
  assign p_clamp   = (p_q > src_m1) ? src_m1 : p_q;
  assign wbase     = nxt_q * cfg_i.taps;
  assign slot_free = !ov_q || out_ready_i;
  assign eol       = (prx_q >= cfg_i.src) && (nxt_q >= cfg_i.tgt);
  assign rdy       = cfg_i.nearest ? (near_idx < prx_q) : (win_end < prx_q);
  assign wsig      = w_rd_q;
  assign line_raddr = (state_q == ST_MAC) ? p_clamp[LineAw-1:0] : near_idx[LineAw-1:0];

  assign line_we = (state_q == ST_IDLE) && !empty_i && (head_i.kind == KIND_PIXEL) &&
                   (prx_q < cfg_i.src);
  assign w_we    = (state_q == ST_IDLE) && !empty_i && (head_i.kind == KIND_WEIGHT);
  assign win_we  = (state_q == ST_IDLE) && !empty_i && (head_i.kind == KIND_START) &&
                   (head_i.idx < WaddrW'(MaxLine));

  always_ff @(posedge clk_i) begin
    if (line_we) line_mem[prx_q[LineAw-1:0]] <= {head_i.c, head_i.b, head_i.a};
    line_rd_q <= line_mem[line_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) weight_mem[head_i.idx] <= head_i.value;
    w_rd_q <= weight_mem[widx_q];
  end

  always_ff @(posedge clk_i) begin
    if (win_we) win_mem[head_i.idx[LineAw-1:0]] <= head_i.value[LineAw-1:0];
    win_rd_q <= win_mem[nxt_q[LineAw-1:0]];
  end

  always_comb begin
    state_d = state_q;
    prx_d = prx_q;  nxt_d = nxt_q;  pos_d = pos_q;  cnt_d = cnt_q;
    pend_v_d = pend_v_q;
    pa_d = pa_q;  pb_d = pb_q;  pc_d = pc_q;  ppos_d = ppos_q;  pdone_d = pdone_q;
    ov_d = ov_q;
    oa_d = oa_q;  ob_d = ob_q;  oc_d = oc_q;  opos_d = opos_q;
    olast_d = olast_q;  odone_d = odone_q;
    t_d = t_q;  p_d = p_q;  widx_d = widx_q;
    v1_d = 1'b0;  v2_d = v1_q;
    pra_d = pra_q;  prb_d = prb_q;  prc_d = prc_q;
    aca_d = aca_q;  acb_d = acb_q;  acc_d = acc_q;
    pop_o = 1'b0;

    if (ov_q && out_ready_i) ov_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head_i.kind == KIND_PIXEL) begin
            if (prx_q < cfg_i.src) prx_d = prx_q + LenW'(1);
            cnt_d   = '0;
            state_d = ST_CHECK_RD;
          end
        end
      end
      ST_CHECK_RD: begin
        if (nxt_q < cfg_i.tgt && cnt_q < CntW'(MaxResults)) state_d = ST_CHECK_EV;
        else state_d = ST_FINISH;
      end
      ST_CHECK_EV: begin
        if (!rdy) begin
          state_d = ST_FINISH;
        end else if (!pend_v_q || slot_free) begin
          if (pend_v_q) begin
            ov_d = 1'b1;
            oa_d = pa_q;  ob_d = pb_q;  oc_d = pc_q;
            opos_d = ppos_q;  olast_d = 1'b0;  odone_d = pdone_q;
            pend_v_d = 1'b0;
          end
          if (cfg_i.nearest) begin
            pend_v_d = 1'b1;
            pa_d = line_rd_q[ChanW-1:0];
            pb_d = line_rd_q[2*ChanW-1:ChanW];
            pc_d = line_rd_q[3*ChanW-1:2*ChanW];
            ppos_d  = nxt_q[LineAw-1:0];
            pdone_d = (nxt_q == cfg_i.tgt - LenW'(1));
            pos_d   = pos_q + cfg_i.step;
            nxt_d   = nxt_q + LenW'(1);
            cnt_d   = cnt_q + CntW'(1);
            state_d = ST_CHECK_RD;
          end else begin
            t_d    = '0;
            p_d    = {1'b0, win_rd_q};
            widx_d = wbase[WaddrW-1:0];
            aca_d  = '0;  acb_d = '0;  acc_d = '0;
            v2_d   = 1'b0;
            state_d = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        if (t_q < cfg_i.taps) begin
          v1_d   = 1'b1;
          t_d    = t_q + TapW'(1);
          p_d    = p_q + LenW'(1);
          widx_d = widx_q + WaddrW'(1);
        end
        if (v1_q) begin
          pra_d = $signed({1'b0, line_rd_q[ChanW-1:0]}) * wsig;
          prb_d = $signed({1'b0, line_rd_q[2*ChanW-1:ChanW]}) * wsig;
          prc_d = $signed({1'b0, line_rd_q[3*ChanW-1:2*ChanW]}) * wsig;
        end
        if (v2_q) begin
          aca_d = aca_q + AccW'(pra_q);
          acb_d = acb_q + AccW'(prb_q);
          acc_d = acc_q + AccW'(prc_q);
        end
        if (t_q == cfg_i.taps && !v1_q && !v2_q) begin
          pend_v_d = 1'b1;
          pa_d = round_clamp(aca_q);
          pb_d = round_clamp(acb_q);
          pc_d = round_clamp(acc_q);
          ppos_d  = nxt_q[LineAw-1:0];
          pdone_d = (nxt_q == cfg_i.tgt - LenW'(1));
          nxt_d   = nxt_q + LenW'(1);
          cnt_d   = cnt_q + CntW'(1);
          state_d = ST_CHECK_RD;
        end
      end
      ST_FINISH: begin
        if (!pend_v_q || slot_free) begin
          if (pend_v_q) begin
            ov_d = 1'b1;
            oa_d = pa_q;  ob_d = pb_q;  oc_d = pc_q;
            opos_d = ppos_q;  olast_d = 1'b1;  odone_d = pdone_q;
            pend_v_d = 1'b0;
          end
          if (eol) begin
            prx_d = '0;
            nxt_d = '0;
            pos_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      prx_q    <= '0;
      nxt_q    <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      t_q      <= '0;
    end else begin
      state_q  <= state_d;
      prx_q    <= prx_d;
      nxt_q    <= nxt_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
      v1_q     <= v1_d;
      v2_q     <= v2_d;
      t_q      <= t_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q <= pa_d;  pb_q <= pb_d;  pc_q <= pc_d;  ppos_q <= ppos_d;  pdone_q <= pdone_d;
    oa_q <= oa_d;  ob_q <= ob_d;  oc_q <= oc_d;  opos_q <= opos_d;
    olast_q <= olast_d;  odone_q <= odone_d;
    p_q <= p_d;  widx_q <= widx_d;
    pra_q <= pra_d;  prb_q <= prb_d;  prc_q <= prc_d;
    aca_q <= aca_d;  acb_q <= acb_d;  acc_q <= acc_d;
  end

  assign out_valid_o    = ov_q;
  assign res_a_o        = oa_q;
  assign res_b_o        = ob_q;
  assign res_c_o        = oc_q;
  assign out_position_o = opos_q;
  assign run_last_o     = olast_q;
  assign line_done_o    = odone_q;

endmodule

// ----- rtl/core/lanczos_line_resampler.sv -----
// ----------------------------------------------------------------------------
// lanczos_line_resampler
// three-channel line resampler, weighted window filter or nearest pick
// ----------------------------------------------------------------------------
// channel  direction  handshake                  payload
// cfg      in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in       in         in_valid_i / in_ready_o    kind, table index/value, chans
// out      out        out_valid_o / out_ready_i  res a/b/c, position, flags
//
// table writes are taken by the back sequencer while idle; a pixel passes a read
// check and, per result, an event check, then in filter mode the mac pipeline
// (one tap per cycle) or in nearest mode a direct pick of the nearest pixel.
// no clearing pass after reset; the two-entry queue absorbs input while the
// back works, and a full output register stalls the back and, once the queue fills, the input.
// ----------------------------------------------------------------------------
module lanczos_line_resampler import llr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgAw-1:0]           cfg_index_i,
  input  logic [StepW-1:0]           cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 kind_i,
  input  logic [WaddrW-1:0]          table_index_i,
  input  logic signed [WeightW-1:0]  table_value_i,
  input  logic [ChanW-1:0]           chan_a_i,
  input  logic [ChanW-1:0]           chan_b_i,
  input  logic [ChanW-1:0]           chan_c_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ChanW-1:0]           res_a_o,
  output logic [ChanW-1:0]           res_b_o,
  output logic [ChanW-1:0]           res_c_o,
  output logic [LineAw-1:0]          out_position_o,
  output logic                       run_last_o,
  output logic                       line_done_o
);

  cfg_t  cfg;
  item_t push_item;
  item_t head;
  logic  push, pop, q_empty, q_full;

  llr_front u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .kind_i, .table_index_i, .table_value_i,
    .chan_a_i, .chan_b_i, .chan_c_i,
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (push_item),
    .cfg_o    (cfg)
  );

  llr_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  llr_back u_back (
    .clk_i, .rst_ni,
    .cfg_i   (cfg),
    .head_i  (head),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_valid_o, .out_ready_i,
    .res_a_o, .res_b_o, .res_c_o, .out_position_o, .run_last_o, .line_done_o
  );

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_a_o) &&
    $stable(out_position_o))
    else $error("output changed while stalled");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_done_o |-> run_last_o)
    else $error("line end item not last of its run");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule
